>>> hdl/table_driven_fsm_event_stack_unit_assert.svh
// Assertion macros shared by the checker of the event stack unit.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TABLE_DRIVEN_FSM_EVENT_STACK_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_FSM_EVENT_STACK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TDFSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TDFSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tdfsm_pkg.sv
// Shared types, field widths and codes of the table driven state machine unit.
// No dependencies; used by every module of the block.
package tdfsm_pkg;

	// Default parameter values
	localparam int DEF_STATE_BITS  = 8;
	localparam int DEF_EVENT_BITS  = 8;
	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_STACK_DEPTH = 16;

	// Port field widths
	localparam int ACTION_W       = 2;
	localparam int EVENT_CODE_W   = 8;
	localparam int ENTRY_INDEX_W  = 5;
	localparam int STATE_FIELD_W  = 8;
	localparam int STATUS_W       = 3;
	localparam int COUNT_FIELD_W  = 5;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 8;
	localparam int TABLE_LENGTH_W = 6;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH    = 2'd0,
		ACT_PROCESS = 2'd1,
		ACT_WRITE   = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_DROPPED = 3'd3,
		ST_MOVED   = 3'd4,
		ST_DONE    = 3'd5
	} status_t;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STATE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH  = 2'd1;

	typedef struct packed {
		logic [STATE_FIELD_W-1:0]  start_state;
		logic [TABLE_LENGTH_W-1:0] table_length;
	} cfg_t;

	typedef struct packed {
		status_t                  status;
		logic [STATE_FIELD_W-1:0] present_state;
		logic [COUNT_FIELD_W-1:0] pending_count;
		logic [COUNT_FIELD_W-1:0] high_water;
	} result_t;

endpackage

>>> hdl/tdfsm_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// Depends on tdfsm_pkg for default sizes.
module tdfsm_ram #(
	parameter int WIDTH = tdfsm_pkg::DEF_EVENT_BITS,
	parameter int DEPTH = tdfsm_pkg::DEF_STACK_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tdfsm_ctrl.sv
// Sequencer of the unit: stack push/pop, table writes, restarts and the table scan.
// Depends on tdfsm_pkg; drives the table and stack RAMs instantiated in the top level.
module tdfsm_ctrl #(
	parameter int STATE_BITS  = tdfsm_pkg::DEF_STATE_BITS,
	parameter int EVENT_BITS  = tdfsm_pkg::DEF_EVENT_BITS,
	parameter int TABLE_DEPTH = tdfsm_pkg::DEF_TABLE_DEPTH,
	parameter int STACK_DEPTH = tdfsm_pkg::DEF_STACK_DEPTH,
	localparam int ENT_W  = 2 * STATE_BITS + EVENT_BITS,
	localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input item
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [tdfsm_pkg::ACTION_W-1:0]         action,
	input  logic [tdfsm_pkg::EVENT_CODE_W-1:0]     event_code,
	input  logic [tdfsm_pkg::ENTRY_INDEX_W-1:0]    entry_index,
	input  logic [tdfsm_pkg::STATE_FIELD_W-1:0]    entry_from_state,
	input  logic [tdfsm_pkg::EVENT_CODE_W-1:0]     entry_event,
	input  logic [tdfsm_pkg::STATE_FIELD_W-1:0]    entry_to_state,
	input  tdfsm_pkg::cfg_t                        cfg,
	// result toward the output register
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output tdfsm_pkg::result_t                     res,
	// transition table RAM
	output logic                                   tbl_we,
	output logic [TIDX_W-1:0]                      tbl_waddr,
	output logic [ENT_W-1:0]                       tbl_wdata,
	output logic                                   tbl_re,
	output logic [TIDX_W-1:0]                      tbl_raddr,
	input  logic [ENT_W-1:0]                       tbl_rdata,
	// event stack RAM
	output logic                                   stk_we,
	output logic [SIDX_W-1:0]                      stk_waddr,
	output logic [EVENT_BITS-1:0]                  stk_wdata,
	output logic                                   stk_re,
	output logic [SIDX_W-1:0]                      stk_raddr,
	input  logic [EVENT_BITS-1:0]                  stk_rdata
);

	import tdfsm_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int LIM_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_RESULT
	} seq_t;

	seq_t                  st_q;
	logic [STATE_BITS-1:0] state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      peak_q;
	status_t               status_q;
	logic [EVENT_BITS-1:0] ev_q;
	logic [TIDX_W-1:0]     idx_q;
	logic [LIM_W-1:0]      lim_q;

	logic                  accept;
	action_t               act;
	logic                  full;
	logic                  slot_ok;
	logic [LIM_W-1:0]      lim;
	logic [CNT_W-1:0]      cnt_inc;
	logic [STATE_BITS-1:0] ent_from;
	logic [EVENT_BITS-1:0] ent_ev;
	logic [STATE_BITS-1:0] ent_to;
	logic                  match;
	logic                  last;

	assign act      = action_t'(action);
	assign in_stall = (st_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign slot_ok  = (32'(entry_index) < 32'(TABLE_DEPTH));

	// entries searched: table_length clipped to the table size
	assign lim = (32'(cfg.table_length) > 32'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
	                                                         : LIM_W'(cfg.table_length);

	// table entry fields, from-state on top
	assign ent_from = tbl_rdata[ENT_W-1 -: STATE_BITS];
	assign ent_ev   = tbl_rdata[STATE_BITS +: EVENT_BITS];
	assign ent_to   = tbl_rdata[STATE_BITS-1:0];
	assign match    = (ent_from == state_q) && (ent_ev == ev_q);
	assign last     = ((LIM_W'(idx_q) + LIM_W'(1)) == lim_q);

	// table RAM: write on a table-write transaction, read while scanning
	assign tbl_we    = accept && (act == ACT_WRITE) && slot_ok;
	assign tbl_waddr = TIDX_W'(entry_index);
	assign tbl_wdata = {STATE_BITS'(entry_from_state), EVENT_BITS'(entry_event),
	                    STATE_BITS'(entry_to_state)};
	assign tbl_re    = (st_q == S_POP && lim_q != '0) ||
	                   (st_q == S_SCAN && !match && !last);
	assign tbl_raddr = (st_q == S_POP) ? '0 : idx_q + TIDX_W'(1);

	// stack RAM: push writes the top slot, process reads the newest event
	assign stk_we    = accept && (act == ACT_PUSH) && !full;
	assign stk_waddr = SIDX_W'(cnt_q);
	assign stk_wdata = EVENT_BITS'(event_code);
	assign stk_re    = accept && (act == ACT_PROCESS) && (cnt_q != '0);
	assign stk_raddr = SIDX_W'(cnt_q - CNT_W'(1));

	// result view of the architectural state
	assign res_valid         = (st_q == S_RESULT);
	assign res.status        = status_q;
	assign res.present_state = STATE_FIELD_W'(state_q);
	assign res.pending_count = COUNT_FIELD_W'(cnt_q);
	assign res.high_water    = COUNT_FIELD_W'(peak_q);

	// sequencer and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			state_q  <= '0;
			cnt_q    <= '0;
			peak_q   <= '0;
			status_q <= ST_DONE;
			ev_q     <= '0;
			idx_q    <= '0;
			lim_q    <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= S_RESULT;
						unique case (act)
							ACT_PUSH: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_PUSHED;
									cnt_q    <= cnt_inc;
									if (cnt_inc > peak_q) begin
										peak_q <= cnt_inc;
									end
								end
							end
							ACT_PROCESS: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									cnt_q <= cnt_q - CNT_W'(1);
									lim_q <= lim;
									st_q  <= S_POP;
								end
							end
							ACT_WRITE: begin
								status_q <= ST_DONE;
							end
							ACT_RESTART: begin
								status_q <= ST_DONE;
								state_q  <= STATE_BITS'(cfg.start_state);
								cnt_q    <= '0;
								peak_q   <= '0;
							end
							default: begin
								status_q <= ST_DONE;
							end
						endcase
					end
				end
				S_POP: begin
					// popped event arrives; entry 0 is being read
					ev_q  <= stk_rdata;
					idx_q <= '0;
					if (lim_q == '0) begin
						status_q <= ST_DROPPED;
						st_q     <= S_RESULT;
					end else begin
						st_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						state_q  <= ent_to;
						status_q <= ST_MOVED;
						st_q     <= S_RESULT;
					end else if (last) begin
						status_q <= ST_DROPPED;
						st_q     <= S_RESULT;
					end else begin
						idx_q <= idx_q + TIDX_W'(1);
					end
				end
				S_RESULT: begin
					if (res_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/table_driven_fsm_event_stack_unit.sv
// Top level of the table driven state machine unit with an event stack.
// Depends on tdfsm_pkg, tdfsm_ram and tdfsm_ctrl.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   input   | in_valid / in_stall  | action, event_code, entry_index, entry_from_state,
//           |                      | entry_event, entry_to_state
//   output  | out_valid / out_stall| status, present_state, pending_count, high_water
//   config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Push, table write, restart and an empty-stack process go straight to the result state;
// processing pops the stack, then scans at most TABLE_DEPTH entries, stopping at a match;
// the scan reads the table RAM one entry per cycle.
// One item is in flight; the next is accepted while its result waits in the output register.
// Reset clears state, counts, registers and the output valid flag; output data and RAMs
// are not cleared.
// Accesses to each RAM never overlap in time, so no forwarding is needed.
module table_driven_fsm_event_stack_unit #(
	parameter int STATE_BITS  = tdfsm_pkg::DEF_STATE_BITS,
	parameter int EVENT_BITS  = tdfsm_pkg::DEF_EVENT_BITS,
	parameter int TABLE_DEPTH = tdfsm_pkg::DEF_TABLE_DEPTH,
	parameter int STACK_DEPTH = tdfsm_pkg::DEF_STACK_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tdfsm_pkg::ACTION_W-1:0]      action,
	input  logic [tdfsm_pkg::EVENT_CODE_W-1:0]  event_code,
	input  logic [tdfsm_pkg::ENTRY_INDEX_W-1:0] entry_index,
	input  logic [tdfsm_pkg::STATE_FIELD_W-1:0] entry_from_state,
	input  logic [tdfsm_pkg::EVENT_CODE_W-1:0]  entry_event,
	input  logic [tdfsm_pkg::STATE_FIELD_W-1:0] entry_to_state,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tdfsm_pkg::STATUS_W-1:0]      status,
	output logic [tdfsm_pkg::STATE_FIELD_W-1:0] present_state,
	output logic [tdfsm_pkg::COUNT_FIELD_W-1:0] pending_count,
	output logic [tdfsm_pkg::COUNT_FIELD_W-1:0] high_water,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tdfsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tdfsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import tdfsm_pkg::*;

	localparam int ENT_W  = 2 * STATE_BITS + EVENT_BITS;
	localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	cfg_t                  cfg_q;
	result_t               res;
	result_t               out_q;
	logic                  out_valid_q;
	logic                  res_valid;
	logic                  res_ready;

	logic                  tbl_we;
	logic [TIDX_W-1:0]     tbl_waddr;
	logic [ENT_W-1:0]      tbl_wdata;
	logic                  tbl_re;
	logic [TIDX_W-1:0]     tbl_raddr;
	logic [ENT_W-1:0]      tbl_rdata;
	logic                  stk_we;
	logic [SIDX_W-1:0]     stk_waddr;
	logic [EVENT_BITS-1:0] stk_wdata;
	logic                  stk_re;
	logic [SIDX_W-1:0]     stk_raddr;
	logic [EVENT_BITS-1:0] stk_rdata;

	// configuration registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INITIAL_STATE: cfg_q.start_state  <= cfg_data;
				REG_TABLE_LENGTH:  cfg_q.table_length <= TABLE_LENGTH_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// output register between the sequencer and the downstream side
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign present_state = out_q.present_state;
	assign pending_count = out_q.pending_count;
	assign high_water    = out_q.high_water;

	tdfsm_ctrl #(
		.STATE_BITS  (STATE_BITS),
		.EVENT_BITS  (EVENT_BITS),
		.TABLE_DEPTH (TABLE_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.event_code       (event_code),
		.entry_index      (entry_index),
		.entry_from_state (entry_from_state),
		.entry_event      (entry_event),
		.entry_to_state   (entry_to_state),
		.cfg              (cfg_q),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.res              (res),
		.tbl_we           (tbl_we),
		.tbl_waddr        (tbl_waddr),
		.tbl_wdata        (tbl_wdata),
		.tbl_re           (tbl_re),
		.tbl_raddr        (tbl_raddr),
		.tbl_rdata        (tbl_rdata),
		.stk_we           (stk_we),
		.stk_waddr        (stk_waddr),
		.stk_wdata        (stk_wdata),
		.stk_re           (stk_re),
		.stk_raddr        (stk_raddr),
		.stk_rdata        (stk_rdata)
	);

	// transition table: {from_state, event, to_state}
	tdfsm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// pending event stack
	tdfsm_ram #(
		.WIDTH (EVENT_BITS),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

endmodule

>>> hdl/tdfsm_checker.sv
// Port-level checker of the table driven state machine unit, bound to the top level.
// Depends on tdfsm_pkg and table_driven_fsm_event_stack_unit_assert.svh.
`include "table_driven_fsm_event_stack_unit_assert.svh"

module tdfsm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [tdfsm_pkg::STATUS_W-1:0]      status,
	input logic [tdfsm_pkg::STATE_FIELD_W-1:0] present_state,
	input logic [tdfsm_pkg::COUNT_FIELD_W-1:0] pending_count,
	input logic [tdfsm_pkg::COUNT_FIELD_W-1:0] high_water
);

	import tdfsm_pkg::*;

	logic [STATUS_W+STATE_FIELD_W+2*COUNT_FIELD_W-1:0] out_bus;

	// whole result payload, for the hold check
	assign out_bus = {status, present_state, pending_count, high_water};

	// a stalled result holds
	`TDFSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus), "stalled result changed")

	// only defined status codes leave the block
	`TDFSM_ASSERT_NOW(a_status_code, out_valid, status <= ST_DONE, "undefined status code")

	// the high-water mark never trails the pending count
	`TDFSM_ASSERT_NOW(a_high_water, out_valid, pending_count <= high_water, "high water below pending count")

	// one item at a time: the cycle after a transaction the input is held off
	`TDFSM_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "input taken while busy")

endmodule

bind table_driven_fsm_event_stack_unit tdfsm_checker u_tdfsm_checker (.*);

>>> test/table_driven_fsm_event_stack_unit_tb.sv
// Self-checking testbench for table_driven_fsm_event_stack_unit: stall-driven item and result
// channels, register writes between phases, and a per-item predictor of the state machine.
// Depends on tdfsm_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module table_driven_fsm_event_stack_unit_tb;
	import tdfsm_pkg::*;

	localparam int TBL_DEPTH      = DEF_TABLE_DEPTH;
	localparam int STK_DEPTH      = DEF_STACK_DEPTH;
	localparam int POOL_N         = 6;
	localparam int PHASE_ITEMS    = 75;
	localparam int SETTLE_CYCLES  = TBL_DEPTH + 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_MAX     = 10;

	// One request as presented on the item channel
	typedef struct packed {
		action_t                  act;
		logic [EVENT_CODE_W-1:0]  ev;
		logic [ENTRY_INDEX_W-1:0] slot;
		logic [STATE_FIELD_W-1:0] from_st;
		logic [EVENT_CODE_W-1:0]  trig;
		logic [STATE_FIELD_W-1:0] to_st;
	} fsm_item_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [ACTION_W-1:0]      action;
	logic [EVENT_CODE_W-1:0]  event_code;
	logic [ENTRY_INDEX_W-1:0] entry_index;
	logic [STATE_FIELD_W-1:0] entry_from_state;
	logic [EVENT_CODE_W-1:0]  entry_event;
	logic [STATE_FIELD_W-1:0] entry_to_state;
	logic                     out_valid;
	logic                     out_stall;
	logic [STATUS_W-1:0]      status;
	logic [STATE_FIELD_W-1:0] present_state;
	logic [COUNT_FIELD_W-1:0] pending_count;
	logic [COUNT_FIELD_W-1:0] high_water;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	table_driven_fsm_event_stack_unit dut (.*);

	// Shadow of the machine and its registers
	logic [STATE_FIELD_W-1:0]  cur_state;
	logic [STATE_FIELD_W-1:0]  tbl_from [TBL_DEPTH];
	logic [EVENT_CODE_W-1:0]   tbl_trig [TBL_DEPTH];
	logic [STATE_FIELD_W-1:0]  tbl_to [TBL_DEPTH];
	logic [EVENT_CODE_W-1:0]   ev_stack [STK_DEPTH];
	int unsigned               stack_depth;
	int unsigned               peak_depth;
	logic [STATE_FIELD_W-1:0]  restart_state;
	logic [TABLE_LENGTH_W-1:0] scan_length;

	// Stimulus and expectations
	fsm_item_t   pending_items[$];
	result_t     expected_results[$];
	fsm_item_t   drv_item;
	logic        in_taken;
	int unsigned queued_items;
	int unsigned accepted_items;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	logic [STATE_FIELD_W-1:0] state_pool [POOL_N];
	logic [EVENT_CODE_W-1:0]  event_pool [POOL_N];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one item to the shadow machine and return the result it must produce
	function automatic result_t step_machine(input fsm_item_t it);
		result_t r;
		int unsigned lim;
		logic [EVENT_CODE_W-1:0] ev;
		logic hit;
		case (it.act)
			ACT_PUSH: begin
				if (stack_depth >= STK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ev_stack[stack_depth] = it.ev;
					stack_depth++;
					if (stack_depth > peak_depth)
						peak_depth = stack_depth;
					r.status = ST_PUSHED;
				end
			end
			ACT_PROCESS: begin
				if (stack_depth == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stack_depth--;
					ev = ev_stack[stack_depth];
					lim = (scan_length > TBL_DEPTH) ? TBL_DEPTH : scan_length;
					hit = 1'b0;
					r.status = ST_DROPPED;
					// first matching entry wins
					for (int i = 0; i < lim; i++) begin
						if (!hit && tbl_from[i] == cur_state && tbl_trig[i] == ev) begin
							cur_state = tbl_to[i];
							hit = 1'b1;
							r.status = ST_MOVED;
						end
					end
				end
			end
			ACT_WRITE: begin
				tbl_from[it.slot] = it.from_st;
				tbl_trig[it.slot] = it.trig;
				tbl_to[it.slot]   = it.to_st;
				r.status = ST_DONE;
			end
			default: begin
				cur_state   = restart_state;
				stack_depth = 0;
				peak_depth  = 0;
				r.status    = ST_DONE;
			end
		endcase
		r.present_state = cur_state;
		r.pending_count = COUNT_FIELD_W'(stack_depth);
		r.high_water    = COUNT_FIELD_W'(peak_depth);
		return r;
	endfunction

	function automatic fsm_item_t make_item(input action_t a, input logic [7:0] ev,
			input logic [4:0] slot, input logic [7:0] from_st, input logic [7:0] trig,
			input logic [7:0] to_st);
		fsm_item_t it;
		it.act     = a;
		it.ev      = ev;
		it.slot    = slot;
		it.from_st = from_st;
		it.trig    = trig;
		it.to_st   = to_st;
		return it;
	endfunction

	// Mostly pool-based traffic so transitions fire; a slice is raw noise
	function automatic fsm_item_t random_item();
		fsm_item_t it;
		int unsigned roll;
		it.act     = action_t'($urandom_range(3));
		it.ev      = 8'($urandom);
		it.slot    = 5'($urandom);
		it.from_st = 8'($urandom);
		it.trig    = 8'($urandom);
		it.to_st   = 8'($urandom);
		roll = $urandom_range(99);
		if (roll >= 8) begin
			it.ev      = event_pool[$urandom_range(POOL_N - 1)];
			it.from_st = state_pool[$urandom_range(POOL_N - 1)];
			it.trig    = event_pool[$urandom_range(POOL_N - 1)];
			it.to_st   = state_pool[$urandom_range(POOL_N - 1)];
			if (roll < 48)
				it.act = ACT_PUSH;
			else if (roll < 83)
				it.act = ACT_PROCESS;
			else if (roll < 95)
				it.act = ACT_WRITE;
			else
				it.act = ACT_RESTART;
		end
		return it;
	endfunction

	task automatic queue_item(input fsm_item_t it);
		pending_items.push_back(it);
		queued_items++;
	endtask

	// Register write; the shadow copy follows at the accepting edge
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_INITIAL_STATE)
			restart_state = val;
		else if (idx == REG_TABLE_LENGTH)
			scan_length = val[TABLE_LENGTH_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every item is in and every result is out, then let the unit settle
	task automatic wait_idle();
		while (accepted_items != queued_items || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
			default: begin send_idle_pct = 12; recv_stall_pct = 12; end
		endcase
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d: %s expected %0d, got %0d", results_seen, name, exp_v,
					act_v);
		end
	endtask

	// Item driver: present the next item at the falling edge, hold it while stalled
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = pending_items.pop_front();
				in_valid         <= 1'b1;
				action           <= drv_item.act;
				event_code       <= drv_item.ev;
				entry_index      <= drv_item.slot;
				entry_from_state <= drv_item.from_st;
				entry_event      <= drv_item.trig;
				entry_to_state   <= drv_item.to_st;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// Input side: predict on each accepted transaction; watchdog on lack of progress
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(step_machine(drv_item));
				accepted_items++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Result monitor: compare against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result %0d: no result expected, got status %0d state %0d",
						results_seen, status, present_state);
			end else begin
				want = expected_results.pop_front();
				check_field("status", int'(want.status), int'(status));
				check_field("present_state", int'(want.present_state), int'(present_state));
				check_field("pending_count", int'(want.pending_count), int'(pending_count));
				check_field("high_water", int'(want.high_water), int'(high_water));
			end
		end
	end

	initial begin
		logic [TABLE_LENGTH_W-1:0] len;
		logic [STATE_FIELD_W-1:0]  init;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		in_taken         = 1'b0;
		action           = ACT_PUSH;
		event_code       = '0;
		entry_index      = '0;
		entry_from_state = '0;
		entry_event      = '0;
		entry_to_state   = '0;
		out_stall        = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = REG_INITIAL_STATE;
		cfg_data         = '0;
		cur_state        = '0;
		stack_depth      = 0;
		peak_depth       = 0;
		restart_state    = '0;
		scan_length      = '0;
		queued_items     = 0;
		accepted_items   = 0;
		results_seen     = 0;
		mismatches       = 0;
		quiet_cycles     = 0;
		set_idling(0);
		state_pool[0] = 8'h00;
		state_pool[1] = 8'hFF;
		event_pool[0] = 8'h00;
		event_pool[1] = 8'hFF;
		for (int i = 2; i < POOL_N; i++) begin
			state_pool[i] = 8'($urandom);
			event_pool[i] = 8'($urandom);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_INITIAL_STATE, 8'h00);
		write_reg(REG_TABLE_LENGTH, 8'd0);

		// Directed: empty store, drop with no table, fill to full, refused push, restart
		queue_item(make_item(ACT_PROCESS, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00));
		queue_item(make_item(ACT_PUSH, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00));
		queue_item(make_item(ACT_PROCESS, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00));
		queue_item(make_item(ACT_WRITE, 8'h00, 5'd31, 8'hFF, 8'hFF, 8'h00));
		for (int k = 0; k < STK_DEPTH; k++)
			queue_item(make_item(ACT_PUSH, 8'(k * 17), 5'd0, 8'h00, 8'h00, 8'h00));
		queue_item(make_item(ACT_PUSH, 8'hFF, 5'd0, 8'h00, 8'h00, 8'h00));
		queue_item(make_item(ACT_RESTART, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00));
		wait_idle();

		// Directed: one-entry table, a matching event moves the machine
		write_reg(REG_TABLE_LENGTH, 8'd1);
		queue_item(make_item(ACT_WRITE, 8'h00, 5'd0, 8'h00, 8'h55, 8'hFF));
		queue_item(make_item(ACT_PUSH, 8'h55, 5'd0, 8'h00, 8'h00, 8'h00));
		queue_item(make_item(ACT_PROCESS, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00));
		wait_idle();

		// Load every slot before any longer scan can reach it
		set_idling(3);
		for (int s = 0; s < TBL_DEPTH; s++)
			queue_item(make_item(ACT_WRITE, 8'($urandom), 5'(s),
				state_pool[$urandom_range(POOL_N - 1)], event_pool[$urandom_range(POOL_N - 1)],
				state_pool[$urandom_range(POOL_N - 1)]));
		wait_idle();

		// Random phases, each with its own register setting and idling pattern
		for (int p = 0; p < 8; p++) begin
			init = state_pool[$urandom_range(POOL_N - 1)];
			len  = 6'($urandom_range(63));
			case (p)
				0: len = 6'd32;
				1: begin len = 6'd63; init = 8'hFF; end
				2: begin len = 6'd0;  init = 8'h00; end
				3: len = 6'd33;
				4: len = 6'd1;
				default: ;
			endcase
			write_reg(REG_INITIAL_STATE, init);
			// upper data bits beyond the register width must be ignored
			write_reg(REG_TABLE_LENGTH, {2'($urandom), len});
			set_idling(p);
			queue_item(make_item(ACT_RESTART, 8'($urandom), 5'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom)));
			for (int n = 1; n < PHASE_ITEMS; n++)
				queue_item(random_item());
			wait_idle();
		end

		if (expected_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
